// ----- sv/ofr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and tables for the orientation frame rotator.
package ofr_pkg;

    // Defaults for the top-level parameters
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 14;

    // Arctangent table length and step counter width
    localparam int TABLE_LEN = 24;
    localparam int IDX_W     = $clog2(TABLE_LEN);

    // Component and arithmetic widths
    localparam int COMP_W  = 16;
    localparam int ANGLE_IN_W = 17;
    localparam int ANGLE_W = 18;
    localparam int MAG_W   = 14;
    localparam int CW      = 34;
    localparam int PROD_W  = COMP_W + CW;
    localparam int SUM_W   = PROD_W + 2;
    localparam int Q_SHIFT = 30;
    localparam int RND_W   = SUM_W - Q_SHIFT;

    // Angle units: 1/128 degree
    localparam logic signed [ANGLE_W-1:0] ANG_TURN    = 18'sd46080;
    localparam logic signed [ANGLE_W-1:0] ANG_HALF    = 18'sd23040;
    localparam logic signed [ANGLE_W-1:0] ANG_QUARTER = 18'sd11520;

    // Degrees to Q2.30 radians: mag * pi_q30 / 23040 split as
    // mag * PI_INT + (mag * PI_REM) / 23040, and / 23040 as >> 9 then / 45
    localparam int PI_INT_W    = 18;
    localparam int PI_REM_W    = 15;
    localparam int RECIP_W     = 20;
    localparam logic [PI_INT_W-1:0] PI_INT  = 18'd146408;
    localparam logic [PI_REM_W-1:0] PI_REM  = 15'd19106;
    localparam logic [RECIP_W-1:0]  RECIP45 = 20'd745655;
    localparam int PA_W        = 32;
    localparam int PB_W        = 28;
    localparam int DIV_SHIFT   = 9;
    localparam int PBH_W       = PB_W - DIV_SHIFT;
    localparam int RQ_W        = PBH_W + RECIP_W;
    localparam int RECIP_SHIFT = 25;
    localparam int Q_W         = RQ_W - RECIP_SHIFT;

    localparam logic signed [CW-1:0] INV_GAIN = CW'(652032874);

    // Rotation sequencer: four products per component, three components
    localparam int ROT_LAST = 12;

    // Operation codes
    localparam logic [1:0] MODE_YAW   = 2'd0;
    localparam logic [1:0] MODE_PITCH = 2'd1;
    localparam logic [1:0] MODE_ROLL  = 2'd2;
    localparam logic [1:0] MODE_RESET = 2'd3;

    // Basis vector slots in the frame
    localparam logic [1:0] VEC_RIGHT = 2'd0;
    localparam logic [1:0] VEC_UP    = 2'd1;
    localparam logic [1:0] VEC_FRONT = 2'd2;

    typedef logic [2:0][COMP_W-1:0] vec_t;
    typedef logic [2:0][2:0][COMP_W-1:0] frame_t;

    typedef struct packed {
        logic             capture;
        logic             wrap;
        logic             fold;
        logic             conv1;
        logic             conv2;
        logic             conv3;
        logic             cordic_step;
        logic             trig;
        logic             mul_en;
        logic             acc_en;
        logic             load_id;
        logic             out_load;
        logic [1:0]       mode;
        logic [IDX_W-1:0] idx;
    } ofr_cmd_t;

    typedef struct packed {
        logic wrap_done;
    } ofr_status_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] i);
        logic signed [CW-1:0] v;
        unique case (i)
            5'd0:    v = CW'(843314857);
            5'd1:    v = CW'(497837829);
            5'd2:    v = CW'(263043837);
            5'd3:    v = CW'(133525159);
            5'd4:    v = CW'(67021687);
            5'd5:    v = CW'(33543516);
            5'd6:    v = CW'(16775851);
            5'd7:    v = CW'(8388437);
            5'd8:    v = CW'(4194283);
            5'd9:    v = CW'(2097149);
            5'd10:   v = CW'(1048576);
            5'd11:   v = CW'(524288);
            5'd12:   v = CW'(262144);
            5'd13:   v = CW'(131072);
            5'd14:   v = CW'(65536);
            5'd15:   v = CW'(32768);
            5'd16:   v = CW'(16384);
            5'd17:   v = CW'(8192);
            5'd18:   v = CW'(4096);
            5'd19:   v = CW'(2048);
            5'd20:   v = CW'(1024);
            5'd21:   v = CW'(512);
            5'd22:   v = CW'(256);
            5'd23:   v = CW'(128);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Fixed-point one, saturated to the component range
    function automatic logic signed [COMP_W-1:0] unit_value(input int frac_bits);
        logic signed [COMP_W-1:0] v;
        if (frac_bits >= COMP_W - 1)
        begin
            v = 16'sh7FFF;
        end
        else
        begin
            v = COMP_W'(1 << frac_bits);
        end
        return v;
    endfunction

endpackage

// ----- sv/ofr_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the frame rotator: handshakes, state machine and step counter.
module ofr_ctrl import ofr_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    output logic        out_valid,
    input  logic        out_ready,
    input  ofr_status_t status,
    output ofr_cmd_t    cmd
);

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WRAP   = 4'd1;
    localparam logic [3:0] S_FOLD   = 4'd2;
    localparam logic [3:0] S_CONV1  = 4'd3;
    localparam logic [3:0] S_CONV2  = 4'd4;
    localparam logic [3:0] S_CONV3  = 4'd5;
    localparam logic [3:0] S_CORDIC = 4'd6;
    localparam logic [3:0] S_TRIG   = 4'd7;
    localparam logic [3:0] S_ROT    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       mode_reg, mode_next;
    logic             out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.mode   = mode_reg;
        cmd.idx    = idx_reg;
        state_next = state_reg;
        idx_next   = idx_reg;
        mode_next  = mode_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    mode_next   = mode;
                    if (mode == MODE_RESET)
                    begin
                        cmd.load_id = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WRAP;
                    end
                end
            end
            S_WRAP:
            begin
                cmd.wrap = 1'b1;
                if (status.wrap_done)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = S_CONV1;
            end
            S_CONV1:
            begin
                cmd.conv1  = 1'b1;
                state_next = S_CONV2;
            end
            S_CONV2:
            begin
                cmd.conv2  = 1'b1;
                state_next = S_CONV3;
            end
            S_CONV3:
            begin
                cmd.conv3  = 1'b1;
                idx_next   = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (idx_reg == IDX_W'(STEPS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_TRIG;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_TRIG:
            begin
                cmd.trig   = 1'b1;
                idx_next   = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.mul_en = (idx_reg < IDX_W'(ROT_LAST));
                cmd.acc_en = (idx_reg != '0);
                if (idx_reg == IDX_W'(ROT_LAST))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            mode_reg      <= MODE_YAW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/ofr_dp.sv -----
`timescale 1ns / 1ps
// Datapath for the frame rotator: angle reduction, CORDIC, rotation MAC and frame.
module ofr_dp import ofr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [ANGLE_IN_W-1:0] angle_deg,
    input  ofr_cmd_t                     cmd,
    output ofr_status_t                  status,
    output frame_t                       out_frame
);

    localparam logic signed [COMP_W-1:0] UNIT = unit_value(FRAC_BITS);
    localparam logic signed [RND_W-1:0]  SAT_MAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0]  SAT_MIN = RND_W'(-32768);
    localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1 << (Q_SHIFT - 1));

    logic signed [ANGLE_W-1:0] angle_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg, flip_reg;
    logic [PA_W-1:0]           pa_reg;
    logic [PB_W-1:0]           pb_reg;
    logic [Q_W-1:0]            q_reg;
    logic signed [CW-1:0]      x_reg, y_reg, z_reg;
    vec_t                      oa_reg, ob_reg;
    logic signed [PROD_W-1:0]  prod_reg, acc_reg;
    frame_t                    frame_reg, out_reg;

    function automatic logic signed [COMP_W-1:0] pick(input vec_t v, input logic [1:0] k);
        logic signed [COMP_W-1:0] c;
        unique case (k)
            2'd0:    c = v[0];
            2'd1:    c = v[1];
            2'd2:    c = v[2];
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [COMP_W-1:0] sat_comp(input logic signed [RND_W-1:0] v);
        logic [COMP_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[COMP_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[COMP_W-1:0];
        end
        else
        begin
            r = v[COMP_W-1:0];
        end
        return r;
    endfunction

    // Identity frame: unit x, unit y, unit z
    function automatic frame_t identity_frame();
        frame_t f;
        f               = '0;
        f[VEC_RIGHT][0] = UNIT;
        f[VEC_UP][1]    = UNIT;
        f[VEC_FRONT][2] = UNIT;
        return f;
    endfunction

    // Pair selection by operation
    logic [1:0] a_sel, b_sel;
    always_comb
    begin
        unique case (cmd.mode)
            MODE_YAW:   begin a_sel = VEC_FRONT; b_sel = VEC_RIGHT; end
            MODE_PITCH: begin a_sel = VEC_UP;    b_sel = VEC_FRONT; end
            MODE_ROLL:  begin a_sel = VEC_UP;    b_sel = VEC_RIGHT; end
            MODE_RESET: begin a_sel = VEC_UP;    b_sel = VEC_RIGHT; end
        endcase
    end

    // Bring the angle into (-180, +180] degrees, one turn per cycle
    logic signed [ANGLE_W-1:0] wrap_val;
    assign status.wrap_done = (angle_reg <= ANG_HALF) && (angle_reg > -ANG_HALF);
    always_comb
    begin
        priority if (angle_reg > ANG_HALF)
        begin
            wrap_val = angle_reg - ANG_TURN;
        end
        else if (angle_reg <= -ANG_HALF)
        begin
            wrap_val = angle_reg + ANG_TURN;
        end
        else
        begin
            wrap_val = angle_reg;
        end
    end

    // Fold into [-90, +90] degrees and split sign and magnitude
    logic signed [ANGLE_W-1:0] fold_val, fold_abs;
    logic                      fold_flip;
    always_comb
    begin
        priority if (angle_reg > ANG_QUARTER)
        begin
            fold_val  = ANG_HALF - angle_reg;
            fold_flip = 1'b1;
        end
        else if (angle_reg < -ANG_QUARTER)
        begin
            fold_val  = -ANG_HALF - angle_reg;
            fold_flip = 1'b1;
        end
        else
        begin
            fold_val  = angle_reg;
            fold_flip = 1'b0;
        end
        fold_abs = fold_val[ANGLE_W-1] ? -fold_val : fold_val;
    end

    // Radian conversion pieces
    logic [PBH_W-1:0]     pb_hi;
    logic [RQ_W-1:0]      q_prod;
    logic [PA_W-1:0]      z_sum;
    logic signed [CW-1:0] z_pos;
    assign pb_hi  = pb_reg[PB_W-1:DIV_SHIFT];
    assign q_prod = RQ_W'(pb_hi) * RQ_W'(RECIP45);
    assign z_sum  = pa_reg + PA_W'(q_reg);
    assign z_pos  = CW'(z_sum);

    // CORDIC micro-rotation
    logic signed [CW-1:0] x_sh, y_sh, atan_i;
    assign x_sh   = x_reg >>> cmd.idx;
    assign y_sh   = y_reg >>> cmd.idx;
    assign atan_i = atan_q30(cmd.idx);

    // Rotation MAC: product j is component j/4, role j%4
    logic [1:0]               mk, mrole, pk, prole;
    logic [IDX_W-1:0]         pidx;
    logic signed [COMP_W-1:0] op_comp;
    logic signed [CW-1:0]     op_trig;
    logic signed [SUM_W-1:0]  mac_sum;
    logic signed [RND_W-1:0]  mac_rnd;
    logic [COMP_W-1:0]        mac_sat;

    assign mk    = cmd.idx[3:2];
    assign mrole = cmd.idx[1:0];
    assign pidx  = cmd.idx - 1'b1;
    assign pk    = pidx[3:2];
    assign prole = pidx[1:0];

    always_comb
    begin
        op_comp = (mrole == 2'd0 || mrole == 2'd3) ? pick(oa_reg, mk) : pick(ob_reg, mk);
        op_trig = (mrole == 2'd0 || mrole == 2'd2) ? x_reg : y_reg;
        if (prole == 2'd3)
        begin
            mac_sum = SUM_W'(acc_reg) - SUM_W'(prod_reg) + ROUND_HALF;
        end
        else
        begin
            mac_sum = SUM_W'(acc_reg) + SUM_W'(prod_reg) + ROUND_HALF;
        end
        mac_rnd = mac_sum[SUM_W-1:Q_SHIFT];
        mac_sat = sat_comp(mac_rnd);
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            angle_reg <= ANGLE_W'(angle_deg);
        end
        else if (cmd.wrap)
        begin
            angle_reg <= wrap_val;
        end

        if (cmd.fold)
        begin
            mag_reg  <= fold_abs[MAG_W-1:0];
            neg_reg  <= fold_val[ANGLE_W-1];
            flip_reg <= fold_flip;
        end

        if (cmd.conv1)
        begin
            pa_reg <= PA_W'(mag_reg) * PA_W'(PI_INT);
            pb_reg <= PB_W'(mag_reg) * PB_W'(PI_REM);
        end

        if (cmd.conv2)
        begin
            q_reg <= q_prod[RQ_W-1:RECIP_SHIFT];
        end

        if (cmd.conv3)
        begin
            z_reg <= neg_reg ? -z_pos : z_pos;
            x_reg <= INV_GAIN;
            y_reg <= '0;
        end
        else if (cmd.cordic_step)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_i;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_i;
            end
        end
        else if (cmd.trig && flip_reg)
        begin
            x_reg <= -x_reg;
        end

        if (cmd.trig)
        begin
            oa_reg <= frame_reg[a_sel];
            ob_reg <= frame_reg[b_sel];
        end

        if (cmd.mul_en)
        begin
            prod_reg <= op_comp * op_trig;
        end

        if (cmd.acc_en && (prole == 2'd0 || prole == 2'd2))
        begin
            acc_reg <= prod_reg;
        end

        if (cmd.out_load)
        begin
            out_reg <= frame_reg;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= identity_frame();
        end
        else if (cmd.load_id)
        begin
            frame_reg <= identity_frame();
        end
        else if (cmd.acc_en && prole == 2'd1)
        begin
            frame_reg[a_sel][pk] <= mac_sat;
        end
        else if (cmd.acc_en && prole == 2'd3)
        begin
            frame_reg[b_sel][pk] <= mac_sat;
        end
    end

    assign out_frame = out_reg;

endmodule

// ----- sv/orientation_frame_rotator.sv -----
`timescale 1ns / 1ps
// Top level of the orientation frame rotator: controller, datapath and port wiring.
//
// Holds an orientation frame of three basis vectors (right, up, front), each with
// three signed Q1.14 components, and applies one command per input item: yaw
// (front/right), pitch (up/front) or roll (up/right) by a signed angle in 1/128
// degree, or reset to identity. A rotation turns the pair as a' = a*cos + b*sin,
// b' = b*cos - a*sin, rounds half up and saturates each component to 16 bits;
// there is no renormalization, so small drift accumulates. Every item returns
// the whole frame as one result. One item is in work at a time. A rotation passes
// through angle wrap, fold and degree-to-radian conversion, the sine/cosine
// CORDIC (one micro-rotation per cycle), a step that fixes the cosine sign and
// latches the old pair, the single 16x34 multiplier that forms the twelve
// products, and the load of the output register; a reset command goes straight
// to that load. The load waits while an earlier result is still held. The
// result sits in its own output register, so the next item is taken while it
// waits.
module orientation_frame_rotator import ofr_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic signed [ANGLE_IN_W-1:0] angle_deg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COMP_W-1:0]     right_x,
    output logic signed [COMP_W-1:0]     right_y,
    output logic signed [COMP_W-1:0]     right_z,
    output logic signed [COMP_W-1:0]     up_x,
    output logic signed [COMP_W-1:0]     up_y,
    output logic signed [COMP_W-1:0]     up_z,
    output logic signed [COMP_W-1:0]     front_x,
    output logic signed [COMP_W-1:0]     front_y,
    output logic signed [COMP_W-1:0]     front_z
);

    ofr_cmd_t    cmd;
    ofr_status_t status;
    frame_t      out_frame;

    // Sequencer: owns both handshakes and steps the datapath
    ofr_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: angle reduction, CORDIC, rotation MAC, frame and output register
    ofr_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .angle_deg (angle_deg),
        .cmd       (cmd),
        .status    (status),
        .out_frame (out_frame)
    );

    // Unpack the held frame onto the result ports
    assign right_x = out_frame[VEC_RIGHT][0];
    assign right_y = out_frame[VEC_RIGHT][1];
    assign right_z = out_frame[VEC_RIGHT][2];
    assign up_x    = out_frame[VEC_UP][0];
    assign up_y    = out_frame[VEC_UP][1];
    assign up_z    = out_frame[VEC_UP][2];
    assign front_x = out_frame[VEC_FRONT][0];
    assign front_y = out_frame[VEC_FRONT][1];
    assign front_z = out_frame[VEC_FRONT][2];

    // Once an item is taken, hold off the next one until the work is through
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

    // Never overwrite a result that is still waiting to be taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("output register loaded while a result is pending");

    // The frame is never reset and rotated in the same cycle
    a_id_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_id |-> !(cmd.mul_en || cmd.acc_en || cmd.cordic_step))
        else $error("identity load overlaps rotation work");

    // A result appears in the cycle after the output register is loaded
    a_result_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("output load did not raise out_valid");

endmodule
